FILE: rtl/ngga_pkg.sv
// shared types, constants and helpers of the gga sentence parser
// no dependencies; used by the interfaces and all rtl modules

package ngga_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned ValW  = 32;

    localparam logic [7:0] ChDollar = 8'h24;
    localparam logic [7:0] ChComma  = 8'h2C;
    localparam logic [7:0] ChDot    = 8'h2E;
    localparam logic [7:0] DigitBase = 8'd48;

    localparam logic [7:0] LatHemiReset = 8'd78;
    localparam logic [7:0] LonHemiReset = 8'd87;

    localparam logic [2:0] HdrLen    = 3'd6;
    localparam logic [3:0] LastComma = 4'd9;

    // field numbers inside the sentence
    localparam logic [3:0] FldId   = 4'd0;
    localparam logic [3:0] FldTime = 4'd1;
    localparam logic [3:0] FldLat  = 4'd2;
    localparam logic [3:0] FldLatH = 4'd3;
    localparam logic [3:0] FldLon  = 4'd4;
    localparam logic [3:0] FldLonH = 4'd5;

    // register indexes
    localparam logic RegLatHemi = 1'b0;
    localparam logic RegLonHemi = 1'b1;

    typedef struct packed {
        logic [7:0] lat_hemi;
        logic [7:0] lon_hemi;
    } t_cfg;

    typedef struct packed {
        logic [ValW-1:0] time_value;
        logic [ValW-1:0] latitude_value;
        logic [ValW-1:0] longitude_value;
        logic            header_mismatch;
        logic            lat_hemisphere_bad;
        logic            lon_hemisphere_bad;
    } t_result;

    // expected sentence id "$GPGGA", one byte per position
    function automatic logic [7:0] id_byte(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h47;
            3'd4:    ch = 8'h47;
            3'd5:    ch = 8'h41;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // acc*10 + byte - 48, wrapping at 32 bits
    function automatic logic [ValW-1:0] acc_step(input logic [ValW-1:0] acc,
                                                 input logic [7:0] b);
        logic [ValW-1:0] times10;
        times10 = (acc << 3) + (acc << 1);
        return times10 + {{(ValW-8){1'b0}}, b} - {{(ValW-8){1'b0}}, DigitBase};
    endfunction

endpackage

FILE: rtl/ngga_if.sv
// byte request and result request channels of the gga sentence parser
// depends on ngga_pkg

interface ngga_byte_if;
    logic                      valid;
    logic                      ready;
    logic [ngga_pkg::ByteW-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface ngga_result_if;
    logic                      valid;
    logic                      ready;
    logic [ngga_pkg::ValW-1:0] time_value;
    logic [ngga_pkg::ValW-1:0] latitude_value;
    logic [ngga_pkg::ValW-1:0] longitude_value;
    logic                      header_mismatch;
    logic                      lat_hemisphere_bad;
    logic                      lon_hemisphere_bad;

    modport source (output valid, output time_value, output latitude_value,
                    output longitude_value, output header_mismatch,
                    output lat_hemisphere_bad, output lon_hemisphere_bad,
                    input ready);
    modport sink   (input valid, input time_value, input latitude_value,
                    input longitude_value, input header_mismatch,
                    input lat_hemisphere_bad, input lon_hemisphere_bad,
                    output ready);
endinterface

FILE: rtl/ngga_cfg.sv
// apb register file holding the expected hemisphere letters
// depends on ngga_pkg

module ngga_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ngga_pkg::t_cfg    o_cfg
);

    logic [7:0] r_lat_hemi;
    logic [7:0] r_lon_hemi;
    logic       wr_en;
    logic       reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_hemi <= ngga_pkg::LatHemiReset;
            r_lon_hemi <= ngga_pkg::LonHemiReset;
        end else if (wr_en) begin
            if (reg_idx == ngga_pkg::RegLatHemi) begin
                r_lat_hemi <= pwdata[7:0];
            end else begin
                r_lon_hemi <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == ngga_pkg::RegLatHemi) begin
            prdata = {24'd0, r_lat_hemi};
        end else begin
            prdata = {24'd0, r_lon_hemi};
        end
    end

    assign o_cfg.lat_hemi = r_lat_hemi;
    assign o_cfg.lon_hemi = r_lon_hemi;

endmodule

FILE: rtl/ngga_core.sv
// sentence state and field accumulators, one byte per step
// depends on ngga_pkg

module ngga_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  ngga_pkg::t_cfg       i_cfg,
    output logic                 o_emit,
    output ngga_pkg::t_result    o_result
);

    logic        r_in_sentence;
    logic [3:0]  r_field_count;
    logic [2:0]  r_hdr_pos;
    logic [31:0] r_time_acc;
    logic [31:0] r_lat_acc;
    logic [31:0] r_lon_acc;
    logic [2:0]  r_err;

    logic        n_in_sentence;
    logic [3:0]  n_field_count;
    logic [2:0]  n_hdr_pos;
    logic [31:0] n_time_acc;
    logic [31:0] n_lat_acc;
    logic [31:0] n_lon_acc;
    logic [2:0]  n_err;

    // state as seen after a possible restart on '$'
    logic        cur_in;
    logic [3:0]  cur_fc;
    logic [2:0]  cur_hp;
    logic [31:0] cur_time;
    logic [31:0] cur_lat;
    logic [31:0] cur_lon;
    logic [2:0]  cur_err;
    logic        is_dollar;
    logic        is_comma;
    logic [3:0]  fc_inc;

    assign is_dollar = (i_byte == ngga_pkg::ChDollar);
    assign is_comma  = (i_byte == ngga_pkg::ChComma);

    always_comb begin
        if (is_dollar) begin
            cur_in   = 1'b1;
            cur_fc   = '0;
            cur_hp   = '0;
            cur_time = '0;
            cur_lat  = '0;
            cur_lon  = '0;
            cur_err  = '0;
        end else begin
            cur_in   = r_in_sentence;
            cur_fc   = r_field_count;
            cur_hp   = r_hdr_pos;
            cur_time = r_time_acc;
            cur_lat  = r_lat_acc;
            cur_lon  = r_lon_acc;
            cur_err  = r_err;
        end
    end

    assign fc_inc = cur_fc + 4'd1;

    always_comb begin
        n_in_sentence = r_in_sentence;
        n_field_count = r_field_count;
        n_hdr_pos     = r_hdr_pos;
        n_time_acc    = r_time_acc;
        n_lat_acc     = r_lat_acc;
        n_lon_acc     = r_lon_acc;
        n_err         = r_err;
        o_emit        = 1'b0;
        if (cur_in) begin
            n_in_sentence = 1'b1;
            n_field_count = cur_fc;
            n_time_acc    = cur_time;
            n_lat_acc     = cur_lat;
            n_lon_acc     = cur_lon;
            n_err         = cur_err;
            if (cur_fc == ngga_pkg::FldId && cur_hp < ngga_pkg::HdrLen) begin
                n_hdr_pos = cur_hp + 3'd1;
            end else begin
                n_hdr_pos = cur_hp;
            end
            if (is_comma) begin
                n_field_count = fc_inc;
                if (fc_inc >= ngga_pkg::LastComma) begin
                    o_emit        = 1'b1;
                    n_in_sentence = 1'b0;
                end
            end else if (i_byte != ngga_pkg::ChDot) begin
                unique case (cur_fc)
                    ngga_pkg::FldId: begin
                        if (cur_hp >= ngga_pkg::HdrLen
                            || i_byte != ngga_pkg::id_byte(cur_hp)) begin
                            n_err[0] = 1'b1;
                        end
                    end
                    ngga_pkg::FldTime: n_time_acc = ngga_pkg::acc_step(cur_time, i_byte);
                    ngga_pkg::FldLat:  n_lat_acc  = ngga_pkg::acc_step(cur_lat, i_byte);
                    ngga_pkg::FldLon:  n_lon_acc  = ngga_pkg::acc_step(cur_lon, i_byte);
                    ngga_pkg::FldLatH: begin
                        if (i_byte != i_cfg.lat_hemi) begin
                            n_err[1] = 1'b1;
                        end
                    end
                    ngga_pkg::FldLonH: begin
                        if (i_byte != i_cfg.lon_hemi) begin
                            n_err[2] = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result carries the accumulators as they stood before the closing comma
    assign o_result.time_value         = cur_time;
    assign o_result.latitude_value     = cur_lat;
    assign o_result.longitude_value    = cur_lon;
    assign o_result.header_mismatch    = cur_err[0];
    assign o_result.lat_hemisphere_bad = cur_err[1];
    assign o_result.lon_hemisphere_bad = cur_err[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_field_count <= '0;
            r_hdr_pos     <= '0;
            r_time_acc    <= '0;
            r_lat_acc     <= '0;
            r_lon_acc     <= '0;
            r_err         <= '0;
        end else if (i_step) begin
            r_in_sentence <= n_in_sentence;
            r_field_count <= n_field_count;
            r_hdr_pos     <= n_hdr_pos;
            r_time_acc    <= n_time_acc;
            r_lat_acc     <= n_lat_acc;
            r_lon_acc     <= n_lon_acc;
            r_err         <= n_err;
        end
    end

endmodule

FILE: rtl/nmea_gga_field_parser.sv
// top level of the gga sentence parser: input register, core, result register
// depends on ngga_pkg, ngga_if, ngga_cfg, ngga_core
//
// channel    | direction | handshake       | payload
// -----------+-----------+-----------------+------------------------------------
// i_byte     | in        | valid / ready   | byte_in, one sentence character
// o_result   | out       | valid / ready   | time, lat, lon values, three flags
// apb        | in        | psel / penable  | hemisphere letters at 0x0 and 0x4
//
// one byte request is taken every cycle unless a closing comma waits in the
// input register for a full result slot; an accepted byte is processed by the
// core from the input register, and its result, if any, is loaded into the
// result register at the edge that updates the core state with that byte
// the sentence state in the core is updated once per byte; that single
// register update is what sets the one-byte-per-cycle rate while no result stall holds the input
// reset is synchronous and active low; it clears the sentence state, the
// valid flags and loads 'N' and 'W' as the expected hemisphere letters
// while a result waits unaccepted, bytes that close no sentence keep flowing;
// only a byte that would produce a second result holds in the input register

module nmea_gga_field_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ngga_byte_if.sink             i_byte,
    ngga_result_if.source         o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    ngga_pkg::t_cfg    cfg;
    ngga_pkg::t_result core_result;
    logic              core_emit;
    logic              step;
    logic              advance;

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_byte;

    // result register
    logic              r_out_valid;
    ngga_pkg::t_result r_out;

    ngga_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ngga_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_emit   (core_emit),
        .o_result (core_result)
    );

    // a byte moves on unless it makes a result and the result slot stays full
    assign advance = !(core_emit && r_out_valid && !o_result.ready);
    assign step    = r_in_valid && advance;

    assign i_byte.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && core_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && core_emit) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.time_value         = r_out.time_value;
    assign o_result.latitude_value     = r_out.latitude_value;
    assign o_result.longitude_value    = r_out.longitude_value;
    assign o_result.header_mismatch    = r_out.header_mismatch;
    assign o_result.lat_hemisphere_bad = r_out.lat_hemisphere_bad;
    assign o_result.lon_hemisphere_bad = r_out.lon_hemisphere_bad;

endmodule
